// ===== rtl/lrv_pkg.sv =====
// ----------------------------------------------------------------------------
// lrv_pkg
// shared types, result codes and defaults for the log replay validator
// ----------------------------------------------------------------------------
package lrv_pkg;

  localparam int unsigned MAX_TX_PAGES_DEF = 64;

  localparam int unsigned PAGE_W = 31;
  localparam int unsigned SEQ_W  = 31;
  localparam int unsigned SUM_W  = 32;
  localparam int unsigned SIZE_W = 8;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned STAT_W = 3;

  typedef logic [STAT_W-1:0] status_t;

  localparam status_t ST_HELD    = 3'd0;
  localparam status_t ST_APPLY   = 3'd1;
  localparam status_t ST_TORN    = 3'd2;
  localparam status_t ST_SEQ_END = 3'd3;
  localparam status_t ST_SIZE    = 3'd4;
  localparam status_t ST_HALTED  = 3'd5;

  // controller to datapath
  typedef struct packed {
    logic accept;   // input beat taken this cycle
    logic rd;       // read held page at the emit index
    logic emit;     // load an apply result into the output register
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free; // output register can take a result this cycle
    logic tx_done;  // the offered beat closes a transaction
    logic last_idx; // emit index points at the final held page
  } ctrl_sts_t;

endpackage

// ===== rtl/lrv_in_if.sv =====
// ----------------------------------------------------------------------------
// lrv_in_if
// input channel: one log byte with its record header fields per beat
// ----------------------------------------------------------------------------
interface lrv_in_if;
  logic                         valid;
  logic                         ready;
  logic [lrv_pkg::BYTE_W-1:0]   data_byte;
  logic                         last_byte;
  logic [lrv_pkg::PAGE_W-1:0]   page_number;
  logic [lrv_pkg::SEQ_W-1:0]    record_seq;
  logic [lrv_pkg::SIZE_W-1:0]   tx_size;
  logic [lrv_pkg::SUM_W-1:0]    stored_sum;

  modport source (
    output valid, data_byte, last_byte, page_number, record_seq, tx_size, stored_sum,
    input  ready
  );
  modport sink (
    input  valid, data_byte, last_byte, page_number, record_seq, tx_size, stored_sum,
    output ready
  );
endinterface

// ===== rtl/lrv_out_if.sv =====
// ----------------------------------------------------------------------------
// lrv_out_if
// result channel: one status beat per result
// ----------------------------------------------------------------------------
interface lrv_out_if;
  logic                       valid;
  logic                       ready;
  logic [lrv_pkg::STAT_W-1:0] status;
  logic [lrv_pkg::PAGE_W-1:0] apply_page;
  logic                       run_last;
  logic [lrv_pkg::SUM_W-1:0]  computed_sum;

  modport source (
    output valid, status, apply_page, run_last, computed_sum,
    input  ready
  );
  modport sink (
    input  valid, status, apply_page, run_last, computed_sum,
    output ready
  );
endinterface

// ===== rtl/lrv_ram.sv =====
// ----------------------------------------------------------------------------
// lrv_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module lrv_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/lrv_ctrl.sv =====
// ----------------------------------------------------------------------------
// lrv_ctrl
// sequencer: takes log beats, then walks the held pages of a finished transaction
// ----------------------------------------------------------------------------
module lrv_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  lrv_pkg::ctrl_sts_t sts_i,
  output lrv_pkg::ctrl_cmd_t cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0] state_q, state_d;

  assign in_ready_o   = (state_q == S_IDLE) && sts_i.out_free;
  assign cmd_o.accept = in_valid_i && in_ready_o;
  assign cmd_o.rd     = (state_q == S_RD);
  assign cmd_o.emit   = (state_q == S_OUT) && sts_i.out_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_o.accept && sts_i.tx_done) begin
          state_d = S_RD;
        end
      end
      S_RD: begin
        state_d = S_OUT;
      end
      S_OUT: begin
        if (cmd_o.emit) begin
          state_d = sts_i.last_idx ? S_IDLE : S_RD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/lrv_dp.sv =====
// ----------------------------------------------------------------------------
// lrv_dp
// checksum, record checks, held page store and output register
// ----------------------------------------------------------------------------
module lrv_dp #(
  parameter int unsigned MAX_TX_PAGES = lrv_pkg::MAX_TX_PAGES_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  lrv_pkg::ctrl_cmd_t         cmd_i,
  output lrv_pkg::ctrl_sts_t         sts_o,
  input  logic [lrv_pkg::BYTE_W-1:0] data_byte_i,
  input  logic                       last_byte_i,
  input  logic [lrv_pkg::PAGE_W-1:0] page_number_i,
  input  logic [lrv_pkg::SEQ_W-1:0]  record_seq_i,
  input  logic [lrv_pkg::SIZE_W-1:0] tx_size_i,
  input  logic [lrv_pkg::SUM_W-1:0]  stored_sum_i,
  input  logic                       out_ready_i,
  output logic                       out_valid_o,
  output lrv_pkg::status_t           status_o,
  output logic [lrv_pkg::PAGE_W-1:0] apply_page_o,
  output logic                       run_last_o,
  output logic [lrv_pkg::SUM_W-1:0]  computed_sum_o
);

  localparam int unsigned AW = (MAX_TX_PAGES > 1) ? $clog2(MAX_TX_PAGES) : 1;
  localparam int unsigned CW = $clog2(MAX_TX_PAGES + 1);

  logic [lrv_pkg::SUM_W-1:0]  running_sum_q, running_sum_d;
  logic [CW-1:0]              held_count_q, held_count_d;
  logic [lrv_pkg::SIZE_W-1:0] expected_size_q, expected_size_d;
  logic [lrv_pkg::SEQ_W-1:0]  next_seq_q, next_seq_d;
  logic                       halted_q, halted_d;
  logic [lrv_pkg::SUM_W-1:0]  tx_sum_q, tx_sum_d;
  logic [AW-1:0]              idx_q, idx_d;

  logic                       out_valid_q, out_valid_d;
  lrv_pkg::status_t           status_q, status_d;
  logic [lrv_pkg::PAGE_W-1:0] page_q, page_d;
  logic                       run_last_q, run_last_d;
  logic [lrv_pkg::SUM_W-1:0]  osum_q, osum_d;

  logic [lrv_pkg::SUM_W-1:0]  sum_new;
  logic                       count_zero;
  logic                       size_bad;
  logic [lrv_pkg::SIZE_W-1:0] exp_eff;
  logic [CW-1:0]              count_inc;
  lrv_pkg::status_t           code;
  logic                       pass;
  logic                       ram_we;
  logic [lrv_pkg::PAGE_W-1:0] ram_rdata;

  // sum * 33 + byte as shift and add
  assign sum_new = (running_sum_q << 5) + running_sum_q
                 + {{(lrv_pkg::SUM_W - lrv_pkg::BYTE_W){1'b0}}, data_byte_i};

  assign count_zero = (held_count_q == '0);
  assign count_inc  = held_count_q + CW'(1);
  assign exp_eff    = count_zero ? tx_size_i : expected_size_q;
  assign size_bad   = count_zero
                    ? ((tx_size_i == '0) || (32'(tx_size_i) > 32'(MAX_TX_PAGES)))
                    : (tx_size_i != expected_size_q);

  always_comb begin
    pass = 1'b0;
    if (halted_q) begin
      code = lrv_pkg::ST_HALTED;
    end else if (!last_byte_i) begin
      code = lrv_pkg::ST_HELD;
    end else if (sum_new != stored_sum_i) begin
      code = lrv_pkg::ST_TORN;
    end else if (record_seq_i != next_seq_q) begin
      code = lrv_pkg::ST_SEQ_END;
    end else if (size_bad) begin
      code = lrv_pkg::ST_SIZE;
    end else begin
      code = lrv_pkg::ST_HELD;
      pass = 1'b1;
    end
  end

  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign sts_o.tx_done  = pass && (32'(count_inc) >= 32'(exp_eff));
  assign sts_o.last_idx = ((CW'(idx_q) + CW'(1)) == held_count_q);

  assign ram_we = cmd_i.accept && pass;

  lrv_ram #(
    .WIDTH (lrv_pkg::PAGE_W),
    .DEPTH (MAX_TX_PAGES)
  ) u_held (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (held_count_q[AW-1:0]),
    .wdata_i (page_number_i),
    .re_i    (cmd_i.rd),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    running_sum_d   = running_sum_q;
    held_count_d    = held_count_q;
    expected_size_d = expected_size_q;
    next_seq_d      = next_seq_q;
    halted_d        = halted_q;
    tx_sum_d        = tx_sum_q;
    idx_d           = idx_q;
    out_valid_d     = out_valid_q && !out_ready_i;
    status_d        = status_q;
    page_d          = page_q;
    run_last_d      = run_last_q;
    osum_d          = osum_q;

    if (cmd_i.accept) begin
      if (!halted_q) begin
        if (!last_byte_i) begin
          running_sum_d = sum_new;
        end else begin
          running_sum_d = '0;
          if (pass) begin
            held_count_d    = count_inc;
            expected_size_d = exp_eff;
            next_seq_d      = record_seq_i + lrv_pkg::SEQ_W'(1);
            tx_sum_d        = sum_new;
          end else begin
            halted_d = 1'b1;
          end
        end
      end
      if (!sts_o.tx_done) begin
        out_valid_d = 1'b1;
        status_d    = code;
        page_d      = '0;
        run_last_d  = 1'b1;
        osum_d      = halted_q ? '0 : sum_new;
      end
    end

    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
      status_d    = lrv_pkg::ST_APPLY;
      page_d      = ram_rdata;
      run_last_d  = sts_o.last_idx;
      osum_d      = tx_sum_q;
      if (sts_o.last_idx) begin
        idx_d        = '0;
        held_count_d = '0;
      end else begin
        idx_d = idx_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_sum_q   <= '0;
      held_count_q    <= '0;
      expected_size_q <= '0;
      next_seq_q      <= '0;
      halted_q        <= 1'b0;
      idx_q           <= '0;
      out_valid_q     <= 1'b0;
    end else begin
      running_sum_q   <= running_sum_d;
      held_count_q    <= held_count_d;
      expected_size_q <= expected_size_d;
      next_seq_q      <= next_seq_d;
      halted_q        <= halted_d;
      idx_q           <= idx_d;
      out_valid_q     <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tx_sum_q   <= tx_sum_d;
    status_q   <= status_d;
    page_q     <= page_d;
    run_last_q <= run_last_d;
    osum_q     <= osum_d;
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign apply_page_o   = page_q;
  assign run_last_o     = run_last_q;
  assign computed_sum_o = osum_q;

endmodule

// ===== rtl/log_replay_validator.sv =====
// ----------------------------------------------------------------------------
// log_replay_validator
// write-ahead log replay with per-record checksum, sequence and size checks
// ----------------------------------------------------------------------------
// latency: a status result is in the output register the cycle after its beat
// throughput: one log byte per cycle while results are taken as they come and no pages are being applied
// a beat closing a transaction blocks input while its held pages are walked, with
//   one store read and one output load per page, plus any output stalls
// reset (async, active low) clears the running sum, counters, sequence and halt flag;
//   the held page store is not cleared, only written entries are ever read
module log_replay_validator #(
  parameter int unsigned MAX_TX_PAGES = lrv_pkg::MAX_TX_PAGES_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  lrv_in_if.sink    in_i,
  lrv_out_if.source out_o
);

  // command and status between the sequencer and the datapath
  lrv_pkg::ctrl_cmd_t cmd;
  lrv_pkg::ctrl_sts_t sts;

  // sequencer: takes beats while idle, then steps through the held pages
  lrv_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath: running checksum, record checks, held pages, output register
  lrv_dp #(
    .MAX_TX_PAGES (MAX_TX_PAGES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .data_byte_i    (in_i.data_byte),
    .last_byte_i    (in_i.last_byte),
    .page_number_i  (in_i.page_number),
    .record_seq_i   (in_i.record_seq),
    .tx_size_i      (in_i.tx_size),
    .stored_sum_i   (in_i.stored_sum),
    .out_ready_i    (out_o.ready),
    .out_valid_o    (out_o.valid),
    .status_o       (out_o.status),
    .apply_page_o   (out_o.apply_page),
    .run_last_o     (out_o.run_last),
    .computed_sum_o (out_o.computed_sum)
  );

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// drives well-formed write-ahead log transactions with random page bytes and
// header noise through the log replay validator, predicts every status beat
// and compares it; one log break at the end checks the halt behaviour
// ----------------------------------------------------------------------------
typedef struct packed {
  logic [lrv_pkg::BYTE_W-1:0] data_byte;
  logic                       last_byte;
  logic [lrv_pkg::PAGE_W-1:0] page_number;
  logic [lrv_pkg::SEQ_W-1:0]  record_seq;
  logic [lrv_pkg::SIZE_W-1:0] tx_size;
  logic [lrv_pkg::SUM_W-1:0]  stored_sum;
} log_beat_t;

typedef struct packed {
  lrv_pkg::status_t           status;
  logic [lrv_pkg::PAGE_W-1:0] apply_page;
  logic                       run_last;
  logic [lrv_pkg::SUM_W-1:0]  computed_sum;
} replay_result_t;

typedef enum int {BYTES_RANDOM, BYTES_ZERO, BYTES_ONES} byte_fill_e;
typedef enum int {
  BREAK_TORN, BREAK_SEQ, BREAK_SIZE_ZERO, BREAK_SIZE_HIGH, BREAK_SIZE_CHANGE
} log_break_e;

class replay_scoreboard;
  logic [lrv_pkg::SUM_W-1:0]  fold_sum;
  logic [lrv_pkg::PAGE_W-1:0] held_pages [lrv_pkg::MAX_TX_PAGES_DEF];
  int unsigned                held_count;
  logic [lrv_pkg::SIZE_W-1:0] open_size;
  logic [lrv_pkg::SEQ_W-1:0]  want_seq;
  bit                         halted;
  replay_result_t             pending [$];
  int unsigned                mismatches;

  function new();
    fold_sum   = '0;
    held_count = 0;
    open_size  = '0;
    want_seq   = '0;
    halted     = 1'b0;
    mismatches = 0;
  endfunction

  function void queue_result(lrv_pkg::status_t st, logic [lrv_pkg::PAGE_W-1:0] page,
                             logic last, logic [lrv_pkg::SUM_W-1:0] sum);
    replay_result_t r;
    r.status       = st;
    r.apply_page   = page;
    r.run_last     = last;
    r.computed_sum = sum;
    pending.push_back(r);
  endfunction

  function void halt_with(lrv_pkg::status_t code, logic [lrv_pkg::SUM_W-1:0] sum);
    halted = 1'b1;
    queue_result(code, '0, 1'b1, sum);
  endfunction

  function void note_input(log_beat_t b);
    logic [lrv_pkg::SUM_W-1:0] sum;
    if (halted) begin
      queue_result(lrv_pkg::ST_HALTED, '0, 1'b1, '0);
      return;
    end
    sum = fold_sum * 32'd33 + {24'd0, b.data_byte};
    if (!b.last_byte) begin
      fold_sum = sum;
      queue_result(lrv_pkg::ST_HELD, '0, 1'b1, sum);
      return;
    end
    fold_sum = '0;
    if (sum != b.stored_sum) begin
      halt_with(lrv_pkg::ST_TORN, sum);
      return;
    end
    if (b.record_seq != want_seq) begin
      halt_with(lrv_pkg::ST_SEQ_END, sum);
      return;
    end
    if (held_count == 0) begin
      if (b.tx_size == 0 || b.tx_size > lrv_pkg::MAX_TX_PAGES_DEF) begin
        halt_with(lrv_pkg::ST_SIZE, sum);
        return;
      end
      open_size = b.tx_size;
    end else if (b.tx_size != open_size) begin
      halt_with(lrv_pkg::ST_SIZE, sum);
      return;
    end
    held_pages[held_count] = b.page_number;
    held_count++;
    want_seq++;
    if (held_count >= open_size) begin
      for (int unsigned i = 0; i < held_count; i++)
        queue_result(lrv_pkg::ST_APPLY, held_pages[i], (i + 1 == held_count), sum);
      held_count = 0;
    end else begin
      queue_result(lrv_pkg::ST_HELD, '0, 1'b1, sum);
    end
  endfunction

  function void check_result(replay_result_t got);
    replay_result_t want;
    if (pending.size() == 0) begin
      mismatches++;
      $display("%0t: unexpected result, expected none, actual status %0d page %h last %b sum %h",
               $time, got.status, got.apply_page, got.run_last, got.computed_sum);
      return;
    end
    want = pending.pop_front();
    if (got !== want) begin
      mismatches++;
      $display("%0t: mismatch, expected status %0d page %h last %b sum %h",
               $time, want.status, want.apply_page, want.run_last, want.computed_sum);
      $display("%0t:           actual status %0d page %h last %b sum %h",
               $time, got.status, got.apply_page, got.run_last, got.computed_sum);
    end
  endfunction

  function int unsigned outstanding();
    return pending.size();
  endfunction
endclass

module testbench;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  lrv_in_if  in_if ();
  lrv_out_if out_if ();

  log_replay_validator #(
    .MAX_TX_PAGES (lrv_pkg::MAX_TX_PAGES_DEF)
  ) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  replay_scoreboard sb = new();

  // idle odds in percent, changed as the run moves through its phases
  int unsigned src_idle_pct = 22;
  int unsigned snk_idle_pct = 78;
  int unsigned items_sent   = 0;

  // sequence number the next good record carries
  logic [lrv_pkg::SEQ_W-1:0] log_seq = '0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // hard stop in case the block wedges
  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

  // result side: random back-pressure, every taken beat goes to the scoreboard
  always @(posedge clk_i) begin
    replay_result_t got;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got.status       = out_if.status;
        got.apply_page   = out_if.apply_page;
        got.run_last     = out_if.run_last;
        got.computed_sum = out_if.computed_sum;
        sb.check_result(got);
      end
      out_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // one input beat; valid only drops when an idle cycle is actually taken, so
  // back-to-back beats never see a low and a high in the same step
  task automatic send_beat(input log_beat_t b);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.data_byte   <= b.data_byte;
    in_if.last_byte   <= b.last_byte;
    in_if.page_number <= b.page_number;
    in_if.record_seq  <= b.record_seq;
    in_if.tx_size     <= b.tx_size;
    in_if.stored_sum  <= b.stored_sum;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sb.note_input(b);
    items_sent++;
  endtask

  // one log record: middle bytes carry random header noise, which the block
  // ignores; the last byte carries the real header, optionally broken by a
  // flipped checksum bit or a skewed sequence number
  task automatic send_record(input int unsigned n_bytes,
                             input logic [lrv_pkg::PAGE_W-1:0] page,
                             input logic [lrv_pkg::SIZE_W-1:0] size,
                             input logic [lrv_pkg::SUM_W-1:0] sum_flip,
                             input logic [lrv_pkg::SEQ_W-1:0] seq_skew,
                             input byte_fill_e fill);
    logic [lrv_pkg::SUM_W-1:0] sum;
    log_beat_t                 b;
    sum = '0;
    for (int unsigned i = 0; i < n_bytes; i++) begin
      case (fill)
        BYTES_ZERO: b.data_byte = '0;
        BYTES_ONES: b.data_byte = '1;
        default:    b.data_byte = lrv_pkg::BYTE_W'($urandom_range(255));
      endcase
      sum = sum * 32'd33 + {24'd0, b.data_byte};
      if (i + 1 < n_bytes) begin
        b.last_byte   = 1'b0;
        b.page_number = lrv_pkg::PAGE_W'($urandom);
        b.record_seq  = lrv_pkg::SEQ_W'($urandom);
        b.tx_size     = lrv_pkg::SIZE_W'($urandom);
        b.stored_sum  = $urandom;
      end else begin
        b.last_byte   = 1'b1;
        b.page_number = page;
        b.record_seq  = log_seq + seq_skew;
        b.tx_size     = size;
        b.stored_sum  = sum ^ sum_flip;
      end
      send_beat(b);
    end
    log_seq++;
  endtask

  // a complete transaction of well-formed records with random pages
  task automatic run_transaction(input int unsigned size, input int unsigned max_bytes);
    for (int unsigned r = 0; r < size; r++)
      send_record($urandom_range(1, max_bytes), lrv_pkg::PAGE_W'($urandom),
                  lrv_pkg::SIZE_W'(size), '0, '0, BYTES_RANDOM);
  endtask

  initial begin
    log_beat_t  noise;
    log_break_e breakage;
    bit         full_done;
    int unsigned pick;

    full_done = 1'b0;

    in_if.valid       <= 1'b0;
    in_if.data_byte   <= '0;
    in_if.last_byte   <= 1'b0;
    in_if.page_number <= '0;
    in_if.record_seq  <= '0;
    in_if.tx_size     <= '0;
    in_if.stored_sum  <= '0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: lone zero byte on page zero, a one-page transaction
    send_record(1, '0, 8'd1, '0, '0, BYTES_ZERO);
    // all-ones bytes on the top page id
    send_record(3, '1, 8'd1, '0, '0, BYTES_ONES);
    // three records of two bytes, pages held until the third arrives
    for (int unsigned r = 0; r < 3; r++)
      send_record(2, lrv_pkg::PAGE_W'($urandom), 8'd3, '0, '0, BYTES_RANDOM);
    // two longer records
    for (int unsigned r = 0; r < 2; r++)
      send_record(4, lrv_pkg::PAGE_W'($urandom), 8'd2, '0, '0, BYTES_RANDOM);

    // random transactions; sender and receiver idling swap, then both stop
    while (items_sent < 200) begin
      if (items_sent >= 140) begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end else if (items_sent >= 70) begin
        src_idle_pct = 78;
        snk_idle_pct = 22;
      end
      pick = $urandom_range(99);
      if (!full_done && items_sent >= 100) begin
        // the largest transaction, one byte per record to keep it short
        run_transaction(lrv_pkg::MAX_TX_PAGES_DEF, 1);
        full_done = 1'b1;
      end else if (pick < 10) begin
        run_transaction($urandom_range(9, 40), 2);
      end else begin
        run_transaction($urandom_range(1, 6), 4);
      end
    end

    // one broken record to close the log, the block halts from here on
    breakage = log_break_e'($urandom_range(4));
    case (breakage)
      BREAK_TORN:
        send_record($urandom_range(1, 3), lrv_pkg::PAGE_W'($urandom), 8'd2,
                    32'd1 << $urandom_range(31), '0, BYTES_RANDOM);
      BREAK_SEQ:
        send_record($urandom_range(1, 3), lrv_pkg::PAGE_W'($urandom), 8'd2,
                    '0, lrv_pkg::SEQ_W'($urandom_range(1, 1000)), BYTES_RANDOM);
      BREAK_SIZE_ZERO:
        send_record($urandom_range(1, 3), lrv_pkg::PAGE_W'($urandom), 8'd0,
                    '0, '0, BYTES_RANDOM);
      BREAK_SIZE_HIGH:
        send_record($urandom_range(1, 3), lrv_pkg::PAGE_W'($urandom),
                    $urandom_range(1) ? 8'd65 : lrv_pkg::SIZE_W'($urandom_range(66, 255)),
                    '0, '0, BYTES_RANDOM);
      default: begin
        // size changes between the records of one transaction
        send_record(2, lrv_pkg::PAGE_W'($urandom), 8'd4, '0, '0, BYTES_RANDOM);
        send_record(2, lrv_pkg::PAGE_W'($urandom), 8'd5, '0, '0, BYTES_RANDOM);
      end
    endcase

    // halted: anything at all should come back as a halted beat
    for (int unsigned k = 0; k < 8; k++) begin
      noise.data_byte   = lrv_pkg::BYTE_W'($urandom);
      noise.last_byte   = 1'($urandom_range(1));
      noise.page_number = lrv_pkg::PAGE_W'($urandom);
      noise.record_seq  = lrv_pkg::SEQ_W'($urandom);
      noise.tx_size     = lrv_pkg::SIZE_W'($urandom);
      noise.stored_sum  = $urandom;
      send_beat(noise);
    end
    in_if.valid <= 1'b0;

    // drain, then a few cycles for anything stray
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (sb.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/lrv_pkg.sv
rtl/lrv_in_if.sv
rtl/lrv_out_if.sv
rtl/lrv_ram.sv
rtl/lrv_ctrl.sv
rtl/lrv_dp.sv
rtl/log_replay_validator.sv
sim/testbench.sv
